[design/threefry_2x32_20round_block_core_defines.svh]
// assertion macros for the threefry 2x32 block core
`ifndef THREEFRY_2X32_20ROUND_BLOCK_CORE_DEFINES_SVH
`define THREEFRY_2X32_20ROUND_BLOCK_CORE_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TF2_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define TF2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tf2_pkg.sv]
// shared types and constants for the threefry 2x32 block core
`timescale 1ns / 1ps
`default_nettype none

package tf2_pkg;

    localparam int TF2_WORD_W    = 32;
    localparam int TF2_KEY_W     = 64;
    localparam int TF2_CTR_W     = 64;
    localparam int TF2_OUT_W     = 64;
    localparam int TF2_GROUPS    = 5;
    localparam int TF2_CELLS_PER = 5;
    localparam int TF2_INJ_POS   = 4;
    localparam int TF2_NUM_CELLS = TF2_GROUPS * TF2_CELLS_PER;

    localparam logic [TF2_WORD_W-1:0] TF2_PARITY = 32'h1BD1_1BDA;

    // [set][position], set 0 = 13,15,26,6 and set 1 = 17,29,16,24
    localparam logic [1:0][3:0][4:0] TF2_ROT = {
        5'd24, 5'd16, 5'd29, 5'd17,
        5'd6,  5'd26, 5'd15, 5'd13
    };

    typedef struct packed {
        logic [TF2_WORD_W-1:0] a;
        logic [TF2_WORD_W-1:0] b;
        logic [TF2_WORD_W-1:0] k0;
        logic [TF2_WORD_W-1:0] k1;
        logic [TF2_WORD_W-1:0] k2;
    } tf2_lane_t;

endpackage

`default_nettype wire

[design/tf2_cell.sv]
// one pipeline cell: a single add-rotate-xor round or a key injection
`timescale 1ns / 1ps
`default_nettype none

module tf2_cell
    import tf2_pkg::*;
#(
    parameter int GROUP = 0,
    parameter int POS   = 0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire tf2_lane_t in_lane,
    output logic           out_valid,
    output tf2_lane_t      out_lane
);

    localparam int ROT = int'(TF2_ROT[GROUP % 2][POS % 4]);
    localparam int KA  = (GROUP + 1) % 3;
    localparam int KB  = (GROUP + 2) % 3;
    localparam logic [TF2_WORD_W-1:0] GRP_INC = TF2_WORD_W'(GROUP + 1);

    logic                       valid_reg;
    tf2_lane_t                  lane_reg;
    tf2_lane_t                  lane_next;

    generate
        if (POS == TF2_INJ_POS) begin : g_inject
            logic [2:0][TF2_WORD_W-1:0] ks;

            assign ks = {in_lane.k2, in_lane.k1, in_lane.k0};

            always_comb begin
                lane_next   = in_lane;
                lane_next.a = in_lane.a + ks[2'(KA)];
                lane_next.b = in_lane.b + ks[2'(KB)] + GRP_INC;
            end
        end else begin : g_round
            logic [TF2_WORD_W-1:0] a_sum;
            logic [TF2_WORD_W-1:0] b_rot;

            assign a_sum = in_lane.a + in_lane.b;
            assign b_rot = (in_lane.b << ROT) | (in_lane.b >> (TF2_WORD_W - ROT));

            always_comb begin
                lane_next   = in_lane;
                lane_next.a = a_sum;
                lane_next.b = b_rot ^ a_sum;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

`default_nettype wire

[design/threefry_2x32_20round_block_core.sv]
// Threefry-2x32 20-round counter hash: a key setup stage followed by a row of
// 25 cells (four single-round cells and one key-injection cell per group).
// One item is taken every cycle unless the master side stalls; each input
// runs through the setup register and the 25 cell registers. The whole
// pipeline, result register included, advances only while the result register
// is empty or being taken, so m_tready low holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none

`include "threefry_2x32_20round_block_core_defines.svh"

module threefry_2x32_20round_block_core
    import tf2_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [TF2_KEY_W+TF2_CTR_W-1:0] s_tdata,  // key_pair, counter
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [TF2_OUT_W-1:0]                m_tdata   // random_word
);

    logic                    en;
    logic [TF2_NUM_CELLS:0]  vld;
    tf2_lane_t               lane [0:TF2_NUM_CELLS];

    logic [TF2_WORD_W-1:0]   k0_in;
    logic [TF2_WORD_W-1:0]   k1_in;
    logic [TF2_WORD_W-1:0]   c0_in;
    logic [TF2_WORD_W-1:0]   c1_in;

    logic                    setup_valid_reg;
    tf2_lane_t               setup_lane_reg;
    tf2_lane_t               setup_lane_next;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign k1_in = s_tdata[TF2_WORD_W-1:0];
    assign k0_in = s_tdata[TF2_KEY_W-1:TF2_WORD_W];
    assign c1_in = s_tdata[TF2_KEY_W+TF2_WORD_W-1:TF2_KEY_W];
    assign c0_in = s_tdata[TF2_KEY_W+TF2_CTR_W-1:TF2_KEY_W+TF2_WORD_W];

    always_comb begin
        setup_lane_next.k0 = k0_in;
        setup_lane_next.k1 = k1_in;
        setup_lane_next.k2 = k0_in ^ k1_in ^ TF2_PARITY;
        setup_lane_next.a  = c0_in + k0_in;
        setup_lane_next.b  = c1_in + k1_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_valid_reg <= 1'b0;
        end else if (en) begin
            setup_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            setup_lane_reg <= setup_lane_next;
        end
    end

    assign vld[0]  = setup_valid_reg;
    assign lane[0] = setup_lane_reg;

    genvar g, p;
    generate
        for (g = 0; g < TF2_GROUPS; g++) begin : g_group
            for (p = 0; p < TF2_CELLS_PER; p++) begin : g_cell
                tf2_cell #(
                    .GROUP (g),
                    .POS   (p)
                ) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (en),
                    .in_valid  (vld[g*TF2_CELLS_PER+p]),
                    .in_lane   (lane[g*TF2_CELLS_PER+p]),
                    .out_valid (vld[g*TF2_CELLS_PER+p+1]),
                    .out_lane  (lane[g*TF2_CELLS_PER+p+1])
                );
            end
        end
    endgenerate

    assign m_tvalid = vld[TF2_NUM_CELLS];
    assign m_tdata  = {lane[TF2_NUM_CELLS].a, lane[TF2_NUM_CELLS].b};

    `TF2_ASSERT_NEXT(a_input_enters, s_tvalid && s_tready, setup_valid_reg,
        "accepted transfer did not reach the setup stage")
    `TF2_ASSERT_NEXT(a_chain_moves, vld[0] && en, vld[1],
        "setup stage item not handed to the first cell")
    `TF2_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld),
        "pipeline valid bits changed during a stall")
    `TF2_ASSERT_SAME(a_ready_on_empty, !m_tvalid, s_tready,
        "input not ready while result register is empty")

endmodule

`default_nettype wire

[tb/threefry_2x32_20round_block_core_tb.sv]
// testbench for the threefry 2x32 20-round block core: streamed stimulus, predicted words
`timescale 1ns / 1ps
`default_nettype none

module threefry_2x32_20round_block_core_tb
    import tf2_pkg::*;
();

    localparam logic [31:0]      KEY_PARITY  = 32'h1BD1_1BDA;
    // rotation amounts, even groups in entries 0..3, odd groups in 4..7
    localparam logic [7:0][4:0]  ROT_AMOUNTS = {
        5'd24, 5'd16, 5'd29, 5'd17,
        5'd6,  5'd26, 5'd15, 5'd13
    };
    localparam int               RANDOM_ITEMS = 2000;
    localparam int               DRAIN_CYCLES = 60;
    localparam int               STALL_LIMIT  = 2000;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [TF2_KEY_W+TF2_CTR_W-1:0] s_tdata  = '0;  // key_pair, counter
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [TF2_OUT_W-1:0]           m_tdata;        // random_word

    logic [TF2_KEY_W+TF2_CTR_W-1:0] pending_items [$];
    logic [TF2_OUT_W-1:0]           expected_words [$];
    int                             error_count = 0;
    int                             src_gap_left = 0;
    int                             sink_stall_left = 0;
    bit                             src_calm = 1'b0;
    bit                             sink_calm = 1'b0;
    int                             idle_cycles = 0;

    threefry_2x32_20round_block_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] threefry_hash(input logic [63:0] key_pair,
                                                  input logic [63:0] counter);
        logic [31:0] sched [3];
        logic [31:0] lane_x;
        logic [31:0] lane_y;
        int          rot_n;
        int          grp;
        int          rnd;
        sched[0] = key_pair[63:32];
        sched[1] = key_pair[31:0];
        sched[2] = sched[0] ^ sched[1] ^ KEY_PARITY;
        lane_x   = counter[63:32] + sched[0];
        lane_y   = counter[31:0] + sched[1];
        for (grp = 0; grp < 5; grp++) begin
            for (rnd = 0; rnd < 4; rnd++) begin
                lane_x = lane_x + lane_y;
                rot_n  = ROT_AMOUNTS[(grp % 2) * 4 + rnd];
                lane_y = (lane_y << rot_n) | (lane_y >> (32 - rot_n));
                lane_y = lane_y ^ lane_x;
            end
            lane_x = lane_x + sched[(grp + 1) % 3];
            lane_y = lane_y + sched[(grp + 2) % 3] + 32'(grp + 1);
        end
        return {lane_x, lane_y};
    endfunction

    task automatic queue_item(input logic [63:0] key_pair, input logic [63:0] counter);
        pending_items.push_back({counter, key_pair});
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %016h expected %016h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_words.push_back(threefry_hash(s_tdata[63:0], s_tdata[127:64]));
            if (!s_tvalid || s_tready) begin
                if (src_gap_left > 0) begin
                    s_tvalid     <= 1'b0;
                    src_gap_left = src_gap_left - 1;
                end else if (pending_items.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_items.pop_front();
                    if ($urandom_range(0, 31) == 0)
                        src_calm = !src_calm;
                    src_gap_left = src_calm ? 0 : $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [63:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected transfer, random_word", m_tdata, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("random_word", m_tdata, want);
                end
                if ($urandom_range(0, 31) == 0)
                    sink_calm = !sink_calm;
                sink_stall_left = sink_calm ? 0 : $urandom_range(0, 3);
            end
            if (sink_stall_left > 0) begin
                m_tready        <= 1'b0;
                sink_stall_left = sink_stall_left - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] run_key;
        logic [63:0] run_ctr;
        int          run_len;
        int          added;
        int          i;

        // directed corners
        queue_item(64'h0, 64'h0);
        queue_item('1, '1);
        queue_item(64'h0, '1);
        queue_item('1, 64'h0);
        queue_item({32'hFFFF_FFFF, 32'h0}, {32'h0, 32'hFFFF_FFFF});
        queue_item({32'h0, 32'hFFFF_FFFF}, {32'hFFFF_FFFF, 32'h0});
        queue_item({KEY_PARITY, 32'h0}, 64'h0);
        queue_item({32'h0, KEY_PARITY}, 64'h1);
        queue_item({32'h1234_5678, 32'h1234_5678 ^ KEY_PARITY}, '1);
        queue_item(64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF);
        queue_item(64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000);
        queue_item(64'h0, 64'h0000_0000_FFFF_FFFF);
        queue_item(64'h0, 64'h0000_0001_0000_0000);
        queue_item(64'h5555_5555_AAAA_AAAA, 64'hAAAA_AAAA_5555_5555);
        queue_item(64'h0000_0000_0000_0001, 64'h0);
        queue_item(64'h0000_0001_0000_0000, 64'h0);

        // random part
        added = 0;
        while (added < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin
                    queue_item({$urandom, $urandom}, {$urandom, $urandom});
                    added++;
                end
                1: begin
                    // one key over a run of consecutive counters
                    run_key = {$urandom, $urandom};
                    run_ctr = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                          : 64'(32'hFFFF_FFF8);
                    run_len = $urandom_range(1, 16);
                    for (i = 0; i < run_len; i++) begin
                        queue_item(run_key, run_ctr);
                        run_ctr = run_ctr + 1;
                    end
                    added += run_len;
                end
                default: begin
                    queue_item({pick_word(), pick_word()}, {pick_word(), pick_word()});
                    added++;
                end
            endcase
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_words.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/tf2_pkg.sv
design/tf2_cell.sv
design/threefry_2x32_20round_block_core.sv
tb/threefry_2x32_20round_block_core_tb.sv
